// ----- rtl/core/baro_altitude_with_peak_defines.svh -----
// Assertion macros for the checker file of the altitude block.
`ifndef BARO_ALTITUDE_WITH_PEAK_DEFINES_SVH
`define BARO_ALTITUDE_WITH_PEAK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BAP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks reset behavior.
`define BAP_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bap_pkg.sv -----
// Shared constants, register indexes and table generator functions.
package bap_pkg;

    localparam int TABLE_ADDR_BITS = 8;

    localparam int PRESS_W = 17;
    localparam int ALT_W   = 20;
    localparam int CFG_W   = 20;
    localparam int ROM_W   = 18;
    localparam int MUL_W   = 24;
    localparam int PROD_W  = 48;

    localparam logic [0:0] REG_REF_PRESSURE = 1'b0;
    localparam logic [0:0] REG_ALT_OFFSET   = 1'b1;

    localparam logic [PRESS_W-1:0] REF_PRESSURE_RST = 17'd101325;
    localparam logic [MUL_W-1:0]   EXP_Q16          = 24'd12472;
    localparam logic [MUL_W-1:0]   ALT_SCALE_DM     = 24'd443300;

    // Truncated integer square root, one result bit per step.
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] xv;
        logic [63:0] res;
        logic [63:0] bitv;
        xv   = x;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (xv >= res + bitv) begin
                xv  = xv - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + a/2^b) in Q16, by repeated squaring in Q30.
    function automatic logic [ROM_W-1:0] log_rom_entry(input int a, input int b);
        logic [63:0] v;
        logic [63:0] r;
        if (a >= (1 << b)) begin
            return 18'd65536;
        end
        v = (64'(1 << b) + 64'(a)) << (30 - b);
        r = 64'd0;
        for (int i = 0; i < 17; i++) begin
            v = (v * v) >> 30;
            r = r << 1;
            if (v >= (64'd1 << 31)) begin
                v = v >> 1;
                r = r | 64'd1;
            end
        end
        return ROM_W'((r + 64'd1) >> 1);
    endfunction

    // 2^(a/2^b) in Q16, as a product of Q30 roots of two.
    function automatic logic [ROM_W-1:0] exp_rom_entry(input int a, input int b);
        logic [63:0] acc;
        logic [63:0] root;
        if (a >= (1 << b)) begin
            return 18'd131072;
        end
        acc  = 64'd1 << 30;
        root = 64'd2 << 30;
        for (int k = 1; k <= b; k++) begin
            root = isqrt(root << 30);
            if (((a >> (b - k)) & 1) != 0) begin
                acc = (acc * root) >> 30;
            end
        end
        return ROM_W'((acc + 64'd8192) >> 14);
    endfunction

endpackage

// ----- rtl/core/bap_rom.sv -----
// Log2 and exp2 interpolation tables, two adjacent entries per lookup.
module bap_rom #(
    parameter int ADDR_BITS = bap_pkg::TABLE_ADDR_BITS
) (
    input  logic                        sel_exp,
    input  logic [ADDR_BITS-1:0]        addr,
    output logic [bap_pkg::ROM_W-1:0]   entry_lo,
    output logic [bap_pkg::ROM_W-1:0]   entry_hi
);

    localparam int DEPTH = (1 << ADDR_BITS) + 1;

    logic [bap_pkg::ROM_W-1:0] log_tbl [DEPTH];
    logic [bap_pkg::ROM_W-1:0] exp_tbl [DEPTH];
    logic [ADDR_BITS:0]        idx_lo;
    logic [ADDR_BITS:0]        idx_hi;

    // Build both tables at elaboration
    for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
        assign log_tbl[i] = bap_pkg::log_rom_entry(i, ADDR_BITS);
        assign exp_tbl[i] = bap_pkg::exp_rom_entry(i, ADDR_BITS);
    end

    assign idx_lo = {1'b0, addr};
    assign idx_hi = {1'b0, addr} + 1'b1;

    // Select the table for the current step
    assign entry_lo = sel_exp ? exp_tbl[idx_lo] : log_tbl[idx_lo];
    assign entry_hi = sel_exp ? exp_tbl[idx_hi] : log_tbl[idx_hi];

endmodule

// ----- rtl/core/bap_mul.sv -----
// Shared signed multiplier with registered product.
module bap_mul (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [bap_pkg::MUL_W-1:0]   op_a,
    input  logic signed [bap_pkg::MUL_W-1:0]   op_b,
    output logic signed [bap_pkg::PROD_W-1:0]  prod_reg
);

    logic signed [bap_pkg::PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    // Capture the product only on multiply steps
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- rtl/core/baro_altitude_with_peak.sv -----
// Top level: barometric altitude with peak hold, sequenced over one multiplier.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-----------------------
//  input   | s_pressure_pa, s_clear_max             | s_valid / s_ready
//  result  | m_altitude_dm, m_max_altitude_dm       | m_valid / m_ready
//  config  | cfg_addr, cfg_wdata                    | cfg_we, no wait
//
// Each word passes through the states LP, LM, LQ, LN, LR, DM, EP, EM, PW, AM and FIN,
// and no new word is taken before the sequencer returns to idle: five multiplies on
// the shared multiplier, three of them with a table lookup and an add step around it.
// s_ready is high only in the idle state; a new word may enter while a result
// still waits in the output register. A result that is not taken holds the
// sequencer in its last step. Reset is synchronous, active low; it clears the
// peak and loads the register reset values.
module baro_altitude_with_peak #(
    parameter int TABLE_ADDR_BITS = bap_pkg::TABLE_ADDR_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bap_pkg::PRESS_W-1:0]       s_pressure_pa,
    input  logic                              s_clear_max,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bap_pkg::ALT_W-1:0]  m_altitude_dm,
    output logic signed [bap_pkg::ALT_W-1:0]  m_max_altitude_dm,
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_addr,
    input  logic [bap_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int FRAC_BITS = 16 - TABLE_ADDR_BITS;
    localparam int LOG_W     = 22;
    localparam int RAW_W     = 24;
    localparam int T_W       = 19;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b000000000001,
        ST_LP   = 12'b000000000010,
        ST_LM   = 12'b000000000100,
        ST_LQ   = 12'b000000001000,
        ST_LN   = 12'b000000010000,
        ST_LR   = 12'b000000100000,
        ST_DM   = 12'b000001000000,
        ST_EP   = 12'b000010000000,
        ST_EM   = 12'b000100000000,
        ST_PW   = 12'b001000000000,
        ST_AM   = 12'b010000000000,
        ST_FIN  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [bap_pkg::PRESS_W-1:0]       p_reg;
    logic                              clr_reg;
    logic [bap_pkg::PRESS_W-1:0]       p0_reg;
    logic signed [bap_pkg::ALT_W-1:0]  offset_reg;
    logic signed [bap_pkg::ALT_W-1:0]  peak_reg;
    logic [4:0]                        e_reg;
    logic [bap_pkg::ROM_W-1:0]         base_reg;
    logic [bap_pkg::ROM_W-1:0]         step_reg;
    logic [FRAC_BITS-1:0]              frac_reg;
    logic [LOG_W-1:0]                  logp_reg;
    logic signed [LOG_W-1:0]           d_reg;
    logic signed [2:0]                 n_reg;
    logic signed [LOG_W-1:0]           diffw_reg;
    logic                              m_valid_reg;
    logic signed [bap_pkg::ALT_W-1:0]  m_alt_reg;
    logic signed [bap_pkg::ALT_W-1:0]  m_max_reg;

    logic [bap_pkg::PRESS_W-1:0]       p0_eff;
    logic [bap_pkg::PRESS_W-1:0]       x_sel;
    logic [4:0]                        lead;
    logic [bap_pkg::PRESS_W-1:0]       mant;
    logic                              sel_exp;
    logic [TABLE_ADDR_BITS-1:0]        rom_addr;
    logic [FRAC_BITS-1:0]              frac_sel;
    logic [bap_pkg::ROM_W-1:0]         entry_lo;
    logic [bap_pkg::ROM_W-1:0]         entry_hi;
    logic                              mul_en;
    logic signed [bap_pkg::MUL_W-1:0]  op_a;
    logic signed [bap_pkg::MUL_W-1:0]  op_b;
    logic signed [bap_pkg::PROD_W-1:0] prod;
    logic [bap_pkg::ROM_W-1:0]         interp;
    logic [LOG_W-1:0]                  log_val;
    logic signed [T_W-1:0]             t_val;
    logic [bap_pkg::ROM_W:0]           m_val;
    logic [2:0]                        rsh;
    logic [LOG_W-1:0]                  pw;
    logic signed [LOG_W-1:0]           diffw;
    logic signed [RAW_W-1:0]           raw;
    logic signed [RAW_W:0]             alt_full;
    logic signed [bap_pkg::ALT_W-1:0]  alt_sat;
    logic signed [bap_pkg::ALT_W-1:0]  peak_base;
    logic                              out_free;
    logic                              s_acc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Treat a zero reference as one pascal
    assign p0_eff = (p0_reg == '0) ? 17'd1 : p0_reg;
    assign x_sel  = (state_reg == ST_LQ) ? p0_eff : p_reg;

    // Find the leading one of the log operand
    always_comb begin
        lead = 5'd0;
        for (int i = 0; i < bap_pkg::PRESS_W; i++) begin
            if (x_sel[i]) begin
                lead = 5'(i);
            end
        end
    end

    assign mant    = x_sel << (5'd16 - lead);
    assign sel_exp = (state_reg == ST_EP);

    // Rounded exponent product from the shared multiplier
    assign t_val = T_W'((prod + 48'sd32768) >>> 16);

    assign rom_addr = sel_exp ? t_val[15 -: TABLE_ADDR_BITS]
                              : mant[15 -: TABLE_ADDR_BITS];
    assign frac_sel = sel_exp ? t_val[FRAC_BITS-1:0] : mant[FRAC_BITS-1:0];

    bap_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .sel_exp  (sel_exp),
        .addr     (rom_addr),
        .entry_lo (entry_lo),
        .entry_hi (entry_hi)
    );

    // Route operands to the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            ST_LM, ST_LN, ST_EM: begin
                mul_en = 1'b1;
                op_a   = $signed({6'd0, step_reg});
                op_b   = $signed(bap_pkg::MUL_W'(frac_reg));
            end
            ST_DM: begin
                mul_en = 1'b1;
                op_a   = bap_pkg::MUL_W'(d_reg);
                op_b   = $signed(bap_pkg::EXP_Q16);
            end
            ST_AM: begin
                mul_en = 1'b1;
                op_a   = $signed(bap_pkg::ALT_SCALE_DM);
                op_b   = bap_pkg::MUL_W'(diffw_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    bap_mul u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    // Interpolated table value and the log result
    assign interp  = bap_pkg::ROM_W'(prod >>> FRAC_BITS);
    assign log_val = LOG_W'({e_reg, 16'h0000}) + LOG_W'(base_reg) + LOG_W'(interp);
    assign m_val   = (bap_pkg::ROM_W + 1)'(base_reg) + (bap_pkg::ROM_W + 1)'(interp);

    // Scale the mantissa by 2^n, rounding right shifts half up
    always_comb begin
        rsh = 3'(-n_reg);
        if (n_reg >= 0) begin
            pw = LOG_W'(m_val) << n_reg[1:0];
        end else begin
            pw = (LOG_W'(m_val >> (rsh - 3'd1)) + 1'b1) >> 1;
        end
    end

    assign diffw = (p_reg == '0) ? 22'sd65536 : 22'sd65536 - $signed(pw);

    // Final altitude, offset and saturation
    assign raw      = RAW_W'((prod + 48'sd32768) >>> 16);
    assign alt_full = (RAW_W + 1)'(raw) - (RAW_W + 1)'(offset_reg);

    always_comb begin
        if (alt_full > 25'sd524287) begin
            alt_sat = 20'sh7FFFF;
        end else if (alt_full < -25'sd524288) begin
            alt_sat = 20'sh80000;
        end else begin
            alt_sat = bap_pkg::ALT_W'(alt_full);
        end
    end

    assign peak_base = clr_reg ? '0 : peak_reg;

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_LP;
            ST_LP:   state_next = ST_LM;
            ST_LM:   state_next = ST_LQ;
            ST_LQ:   state_next = ST_LN;
            ST_LN:   state_next = ST_LR;
            ST_LR:   state_next = ST_DM;
            ST_DM:   state_next = ST_EP;
            ST_EP:   state_next = ST_EM;
            ST_EM:   state_next = ST_PW;
            ST_PW:   state_next = ST_AM;
            ST_AM:   state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and peak
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            peak_reg    <= '0;
            p0_reg      <= bap_pkg::REF_PRESSURE_RST;
            offset_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    bap_pkg::REG_REF_PRESSURE: p0_reg <= cfg_wdata[bap_pkg::PRESS_W-1:0];
                    bap_pkg::REG_ALT_OFFSET:   offset_reg <= $signed(cfg_wdata);
                    default:                   p0_reg <= p0_reg;
                endcase
            end
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                peak_reg    <= (alt_sat > peak_base) ? alt_sat : peak_base;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p_reg   <= s_pressure_pa;
            clr_reg <= s_clear_max;
        end
        if (state_reg == ST_LP || state_reg == ST_LQ || state_reg == ST_EP) begin
            e_reg    <= lead;
            base_reg <= entry_lo;
            step_reg <= entry_hi - entry_lo;
            frac_reg <= frac_sel;
        end
        if (state_reg == ST_EP) begin
            n_reg <= t_val[T_W-1:16];
        end
        if (state_reg == ST_LQ) begin
            logp_reg <= log_val;
        end
        if (state_reg == ST_LR) begin
            d_reg <= $signed(logp_reg) - $signed(log_val);
        end
        if (state_reg == ST_PW) begin
            diffw_reg <= diffw;
        end
        if (state_reg == ST_FIN && out_free) begin
            m_alt_reg <= alt_sat;
            m_max_reg <= (alt_sat > peak_base) ? alt_sat : peak_base;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_altitude_dm     = m_alt_reg;
    assign m_max_altitude_dm = m_max_reg;

endmodule

// ----- rtl/core/bap_chk.sv -----
// Port-level checker for the altitude block, bound to the top level.
`include "baro_altitude_with_peak_defines.svh"

module bap_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [bap_pkg::PRESS_W-1:0]       s_pressure_pa,
    input logic                              s_clear_max,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [bap_pkg::ALT_W-1:0]  m_altitude_dm,
    input logic signed [bap_pkg::ALT_W-1:0]  m_max_altitude_dm
);

    // Come out of reset idle with no word pending
    `BAP_ASSERT_RST(a_rst_idle, !aresetn, !m_valid && s_ready, "not idle after reset")

    // Drop ready once a word is taken
    `BAP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after accept")

    // The peak never lies below the word it comes with
    `BAP_ASSERT_SAME(a_peak_ge_alt, m_valid, m_max_altitude_dm >= m_altitude_dm, "peak below altitude")

    // Hold a stalled result
    `BAP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_altitude_dm) && $stable(m_max_altitude_dm), "stalled result changed")

    // Hold a waiting input word
    `BAP_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_pressure_pa) && $stable(s_clear_max), "input changed")

endmodule

bind baro_altitude_with_peak bap_chk u_bap_chk (.*);
